>>> rtl/core/vector3_alu_defines.svh
// ----------------------------------------------------------------------------
// vector3_alu assertion macros
// Shared assertion shorthand for the vector unit; expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ALU_DEFINES_SVH
`define VECTOR3_ALU_DEFINES_SVH

// Assert a property on every rising clock edge outside reset.
`define V3A_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("vector3_alu assertion failed");

// Assert that a condition never holds outside reset.
`define V3A_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("vector3_alu forbidden condition seen");

`endif

>>> rtl/core/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg
// Types and constants shared by the vector unit's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package v3a_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;

	localparam logic [3:0] CMD_ADD    = 4'd0;
	localparam logic [3:0] CMD_SUB    = 4'd1;
	localparam logic [3:0] CMD_MUL    = 4'd2;
	localparam logic [3:0] CMD_LERP   = 4'd3;
	localparam logic [3:0] CMD_DOT    = 4'd4;
	localparam logic [3:0] CMD_CROSS  = 4'd5;
	localparam logic [3:0] CMD_LENGTH = 4'd6;
	localparam logic [3:0] CMD_DIST   = 4'd7;
	localparam logic [3:0] CMD_SCALE  = 4'd8;
	localparam logic [3:0] CMD_NORM   = 4'd9;

	typedef struct packed {
		logic [3:0]         command;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] scalar_t;
	} request_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic signed [31:0] r_scalar;
		logic               fault;
	} result_t;

	typedef struct packed {
		logic     long_op;
		request_t req;
	} queue_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/v3a_front.sv
// ----------------------------------------------------------------------------
// v3a_front
// Accepts commands, tags the long (root and divide) ones, and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  v3a_pkg::request_t      request,
	input  logic                   pop,
	output logic                   head_valid,
	output v3a_pkg::queue_entry_t  head
);
	import v3a_pkg::*;

	queue_entry_t        entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                push;
	logic                long_op;

	assign busy       = (count_q == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign push       = start & ~busy;
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	assign long_op = (request.command == CMD_LENGTH) || (request.command == CMD_DIST) ||
		(request.command == CMD_NORM);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{long_op: long_op, req: request};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/v3a_pipe.sv
// ----------------------------------------------------------------------------
// v3a_pipe
// Three-stage pipeline for add, sub, mul, lerp, dot, cross and scale; other codes give a zero result.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_pipe #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  v3a_pkg::request_t in_req,
	output logic              occupied,
	output logic              out_valid,
	output v3a_pkg::result_t  out_res
);
	import v3a_pkg::*;

	localparam logic signed [67:0] HALF  = 68'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [67:0] MAX32 = 68'sd2147483647;
	localparam logic signed [67:0] MIN32 = -68'sd2147483648;

	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	request_t           req_s1;
	logic [3:0]         cmd_s2;
	logic signed [65:0] t0_s2 [3];
	logic signed [65:0] t1_s2 [3];
	result_t            res_s3;

	logic signed [32:0] av [3];
	logic signed [32:0] bv [3];
	logic signed [32:0] tv;
	logic signed [65:0] t0_d [3];
	logic signed [65:0] t1_d [3];
	logic [32:0]        lane_rs [3];
	logic [32:0]        dot_rs;
	result_t            res_d;

	// Round (the half is already added), shift down and clamp: {fault, value}.
	function automatic logic [32:0] round_sat(input logic signed [67:0] s);
		logic signed [67:0] q;
		q = s >>> FRAC_BITS;
		if (q > MAX32) begin
			return {1'b1, 32'h7FFF_FFFF};
		end else if (q < MIN32) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, q[31:0]};
	endfunction

	function automatic logic signed [67:0] ext(input logic signed [65:0] v);
		return {{2{v[65]}}, v};
	endfunction

	assign av[0] = {req_s1.a_x[31], req_s1.a_x};
	assign av[1] = {req_s1.a_y[31], req_s1.a_y};
	assign av[2] = {req_s1.a_z[31], req_s1.a_z};
	assign bv[0] = {req_s1.b_x[31], req_s1.b_x};
	assign bv[1] = {req_s1.b_y[31], req_s1.b_y};
	assign bv[2] = {req_s1.b_z[31], req_s1.b_z};
	assign tv    = {req_s1.scalar_t[31], req_s1.scalar_t};

	// Stage 1: one or two products per lane, a shifted linear term, or both (lerp).
	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		logic signed [32:0] x0, y0, x1, y1, lin;
		logic signed [65:0] prod0, prod1;
		logic               use_lin;

		always_comb begin
			x0      = '0;
			y0      = '0;
			x1      = '0;
			y1      = '0;
			lin     = '0;
			use_lin = 1'b0;
			case (req_s1.command)
				CMD_ADD: begin
					lin     = av[i] + bv[i];
					use_lin = 1'b1;
				end
				CMD_SUB: begin
					lin     = av[i] - bv[i];
					use_lin = 1'b1;
				end
				CMD_MUL, CMD_DOT: begin
					x0 = av[i];
					y0 = bv[i];
				end
				CMD_LERP: begin
					lin     = av[i];
					use_lin = 1'b1;
					x1      = bv[i] - av[i];
					y1      = tv;
				end
				CMD_CROSS: begin
					x0 = av[J];
					y0 = bv[K];
					x1 = av[K];
					y1 = bv[J];
				end
				CMD_SCALE: begin
					x0 = av[i];
					y0 = tv;
				end
				default: begin
					use_lin = 1'b0;
				end
			endcase
		end

		assign prod0   = x0 * y0;
		assign prod1   = x1 * y1;
		assign t0_d[i] = use_lin ? ({{33{lin[32]}}, lin} <<< FRAC_BITS) : prod0;
		assign t1_d[i] = prod1;
	end

	// Stage 2: sum the terms, round and clamp.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lane_rs[i] = round_sat(ext(t0_s2[i]) +
				((cmd_s2 == CMD_CROSS) ? -ext(t1_s2[i]) : ext(t1_s2[i])) + HALF);
		end
		dot_rs = round_sat(ext(t0_s2[0]) + ext(t0_s2[1]) + ext(t0_s2[2]) + HALF);

		res_d = '0;
		case (cmd_s2)
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_LERP, CMD_CROSS, CMD_SCALE: begin
				res_d.r_x   = lane_rs[0][31:0];
				res_d.r_y   = lane_rs[1][31:0];
				res_d.r_z   = lane_rs[2][31:0];
				res_d.fault = lane_rs[0][32] | lane_rs[1][32] | lane_rs[2][32];
			end
			CMD_DOT: begin
				res_d.r_scalar = dot_rs[31:0];
				res_d.fault    = dot_rs[32];
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			req_s1 <= in_req;
		end
		cmd_s2 <= req_s1.command;
		for (int i = 0; i < 3; i++) begin
			t0_s2[i] <= t0_d[i];
			t1_s2[i] <= t1_d[i];
		end
		res_s3 <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign occupied  = valid_s1 | valid_s2;
	assign out_valid = valid_s3;
	assign out_res   = res_s3;

endmodule

`default_nettype wire

>>> rtl/core/v3a_iter.sv
// ----------------------------------------------------------------------------
// v3a_iter
// Iterative unit for length, distance and normalize: squares, root, divide.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_iter #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  v3a_pkg::request_t req,
	output logic              busy,
	output logic              done,
	output v3a_pkg::result_t  res
);
	import v3a_pkg::*;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_SHIFT     = 4'd1;
	localparam logic [3:0] ST_SQUARE    = 4'd2;
	localparam logic [3:0] ST_ROOT      = 4'd3;
	localparam logic [3:0] ST_ROUND     = 4'd4;
	localparam logic [3:0] ST_DIV_LOAD  = 4'd5;
	localparam logic [3:0] ST_DIVIDE    = 4'd6;
	localparam logic [3:0] ST_DIV_STORE = 4'd7;
	localparam logic [3:0] ST_DONE      = 4'd8;

	logic [3:0]         state_q;
	logic               norm_q;
	logic signed [32:0] vec_q [3];
	logic [31:0]        max_q;
	logic [1:0]         lane_q;
	logic [63:0]        prod_q;
	logic [63:0]        acc_q;
	logic [63:0]        root_q;
	logic [63:0]        bit_q;
	logic [31:0]        len_q;
	logic [63:0]        num_q;
	logic [31:0]        drem_q;
	logic [31:0]        quo_q;
	logic [4:0]         cnt_q;
	result_t            res_q;

	logic signed [32:0] dv [3];
	logic [32:0]        dm [3];
	logic [32:0]        m01;
	logic [32:0]        mx;
	logic               huge;
	logic signed [32:0] sel_vec;
	logic [32:0]        sel_mag;
	logic [63:0]        sq;
	logic [63:0]        rb;
	logic [32:0]        trial;
	logic               ge;
	logic [63:0]        nload;
	logic [31:0]        len_d;
	logic [31:0]        qval;
	logic               qsat;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		return v[32] ? -v : v;
	endfunction

	assign dv[0] = (req.command == CMD_DIST) ? ({req.a_x[31], req.a_x} - {req.b_x[31], req.b_x})
		: {req.a_x[31], req.a_x};
	assign dv[1] = (req.command == CMD_DIST) ? ({req.a_y[31], req.a_y} - {req.b_y[31], req.b_y})
		: {req.a_y[31], req.a_y};
	assign dv[2] = (req.command == CMD_DIST) ? ({req.a_z[31], req.a_z} - {req.b_z[31], req.b_z})
		: {req.a_z[31], req.a_z};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dm[i] = mag33(dv[i]);
		end
		huge = dm[0][32] | dm[0][31] | dm[1][32] | dm[1][31] | dm[2][32] | dm[2][31];
		m01  = (dm[0] > dm[1]) ? dm[0] : dm[1];
		mx   = (m01 > dm[2]) ? m01 : dm[2];
	end

	always_comb begin
		case (lane_q)
			2'd0:    sel_vec = vec_q[0];
			2'd1:    sel_vec = vec_q[1];
			2'd2:    sel_vec = vec_q[2];
			default: sel_vec = '0;
		endcase
	end

	assign sel_mag = mag33(sel_vec);
	assign sq      = sel_mag[31:0] * sel_mag[31:0];
	assign rb      = root_q + bit_q;
	assign trial   = {drem_q, num_q[31]};
	assign ge      = (trial >= {1'b0, len_q});
	assign nload   = ({31'b0, sel_mag} << FRAC_BITS) + {33'b0, len_q[31:1]};
	assign len_d   = root_q[31:0] + {31'b0, (acc_q > root_q)};

	// Apply the sign to the quotient and clamp.
	always_comb begin
		qsat = 1'b0;
		qval = quo_q;
		if (!sel_vec[32]) begin
			if (quo_q > 32'h7FFF_FFFF) begin
				qsat = 1'b1;
				qval = 32'h7FFF_FFFF;
			end
		end else begin
			if (quo_q > 32'h8000_0000) begin
				qsat = 1'b1;
				qval = 32'h8000_0000;
			end else begin
				qval = -quo_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						if (req.command == CMD_NORM) begin
							state_q <= (mx == '0) ? ST_DONE : ST_SHIFT;
						end else begin
							state_q <= huge ? ST_DONE : ST_SQUARE;
						end
					end
				end
				ST_SHIFT: begin
					if (max_q[31:30] != 2'b00) begin
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (lane_q == 2'd3) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (bit_q[0]) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND:     state_q <= norm_q ? ST_DIV_LOAD : ST_DONE;
				ST_DIV_LOAD:  state_q <= ST_DIVIDE;
				ST_DIVIDE: begin
					if (cnt_q == 5'd31) begin
						state_q <= ST_DIV_STORE;
					end
				end
				ST_DIV_STORE: state_q <= (lane_q == 2'd2) ? ST_DONE : ST_DIV_LOAD;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_q  <= '0;
				norm_q <= (req.command == CMD_NORM);
				max_q  <= mx[31:0];
				acc_q  <= '0;
				lane_q <= '0;
				for (int i = 0; i < 3; i++) begin
					vec_q[i] <= dv[i];
				end
				if (req.command == CMD_NORM) begin
					res_q.fault <= (mx == '0);
				end else if (huge) begin
					res_q.r_scalar <= 32'h7FFF_FFFF;
					res_q.fault    <= 1'b1;
				end
			end
			ST_SHIFT: begin
				// Shift all components together until the largest fills the word.
				if (max_q[31:30] == 2'b00) begin
					max_q <= max_q << 1;
					for (int i = 0; i < 3; i++) begin
						vec_q[i] <= vec_q[i] <<< 1;
					end
				end
			end
			ST_SQUARE: begin
				if (lane_q != 2'd3) begin
					prod_q <= sq;
				end
				if (lane_q != 2'd0) begin
					acc_q <= acc_q + prod_q;
				end
				lane_q <= lane_q + 1'b1;
				root_q <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
			end
			ST_ROOT: begin
				if (acc_q >= rb) begin
					acc_q  <= acc_q - rb;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_ROUND: begin
				len_q  <= len_d;
				lane_q <= '0;
				if (!norm_q) begin
					if (len_d > 32'h7FFF_FFFF) begin
						res_q.r_scalar <= 32'h7FFF_FFFF;
						res_q.fault    <= 1'b1;
					end else begin
						res_q.r_scalar <= len_d;
					end
				end
			end
			ST_DIV_LOAD: begin
				num_q  <= nload;
				drem_q <= nload[63:32];
				quo_q  <= '0;
				cnt_q  <= '0;
			end
			ST_DIVIDE: begin
				num_q  <= num_q << 1;
				drem_q <= ge ? 32'(trial - {1'b0, len_q}) : trial[31:0];
				quo_q  <= {quo_q[30:0], ge};
				cnt_q  <= cnt_q + 1'b1;
			end
			ST_DIV_STORE: begin
				case (lane_q)
					2'd0:    res_q.r_x <= qval;
					2'd1:    res_q.r_y <= qval;
					default: res_q.r_z <= qval;
				endcase
				if (qsat) begin
					res_q.fault <= 1'b1;
				end
				lane_q <= lane_q + 1'b1;
			end
			default: begin
				lane_q <= lane_q;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign res  = res_q;

endmodule

`default_nettype wire

>>> rtl/core/vector3_alu.sv
// ----------------------------------------------------------------------------
// vector3_alu
// Three-component signed fixed-point vector unit, decoupled front and back.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request and raise start; the transaction is taken on a rising edge
//   where start is high and busy is low. busy rises only when the four-entry
//   command queue is full.
//   Each transaction yields exactly one result: done is high for one cycle
//   with result valid. The receiver cannot hold results off.
// Throughput:
//   add, sub, mul, lerp, dot, cross, scale and unknown codes run through a
//   three-stage multiply/round pipeline, one transaction per cycle sustained
//   while the iterative unit is idle.
//   length and distance run in the iterative unit: four squaring steps and
//   32 root steps; normalize adds shift steps and three divides. The one
//   root/divide unit takes one long transaction at a time; later
//   transactions wait in the queue so results keep order.
// Reset:
//   arst_n clears the queue, pipeline valids and the sequencer; no clearing
//   pass is needed, the block accepts work right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_alu #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  v3a_pkg::request_t request,
	output logic              done,
	output v3a_pkg::result_t  result
);
	import v3a_pkg::*;

	logic         head_valid;
	queue_entry_t head;
	logic         pop;
	logic         pop_simple;
	logic         pop_long;
	logic         pipe_occupied;
	logic         pipe_valid;
	result_t      pipe_res;
	logic         iter_busy;
	logic         iter_done;
	result_t      iter_res;

	// Front: take and tag transactions into the queue.
	v3a_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Dispatch in order: short ops stream while the iterative unit is idle;
	// a long op waits until the first two pipeline stages have drained, so
	// its result can never land on the same cycle as a pipeline result.
	assign pop_simple = head_valid & ~head.long_op & ~iter_busy;
	assign pop_long   = head_valid & head.long_op & ~iter_busy & ~pipe_occupied;
	assign pop        = pop_simple | pop_long;

	v3a_pipe #(
		.FRAC_BITS (FRAC_BITS)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pop_simple),
		.in_req    (head.req),
		.occupied  (pipe_occupied),
		.out_valid (pipe_valid),
		.out_res   (pipe_res)
	);

	v3a_iter #(
		.FRAC_BITS (FRAC_BITS)
	) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (pop_long),
		.req    (head.req),
		.busy   (iter_busy),
		.done   (iter_done),
		.res    (iter_res)
	);

	// Both sources are registered and never fire together.
	assign done   = pipe_valid | iter_done;
	assign result = iter_done ? iter_res : pipe_res;

endmodule

`default_nettype wire

>>> rtl/core/vector3_alu_checker.sv
// ----------------------------------------------------------------------------
// vector3_alu_checker
// Port-level checks on transaction accounting for the vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector3_alu_defines.svh"

module vector3_alu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input v3a_pkg::request_t request,
	input logic              done,
	input v3a_pkg::result_t  result
);
	logic [3:0] outstanding_q;
	logic       accept;

	assign accept = start & ~busy;

	// Track transactions accepted but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + {3'b0, accept} - {3'b0, done};
		end
	end

	`V3A_ASSERT(a_no_invented_result, done |-> (outstanding_q != 4'd0))
	`V3A_NEVER(a_outstanding_bound, outstanding_q > 4'd8)
	`V3A_ASSERT(a_busy_means_full, busy |-> (outstanding_q >= 4'd4))
	`V3A_ASSERT(a_fault_only_with_done, (result.fault && done) |-> (outstanding_q != 4'd0))

endmodule

bind vector3_alu vector3_alu_checker u_checker (.*);

`default_nettype wire

>>> tb/vector3_alu_tb.sv
// ----------------------------------------------------------------------------
// vector3_alu_tb
// Self-checking bench for the fixed-point vector unit: directed corner
// transactions, then random ones under three idling profiles, each result
// compared field by field against a built-in arithmetic predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_alu_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import v3a_pkg::*;

	localparam int FRAC = 16;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	request_t request = '0;
	logic     done;
	result_t  result;

	vector3_alu #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result)
	);

	always #4 clk = ~clk;

	result_t pending_results[$];
	int      mismatch_count = 0;
	int      sent_count = 0;
	int      checked_count = 0;
	int      gap_pct = 0;

	// Saturate a wide value to 32 bits, flagging overflow.
	function automatic logic signed [31:0] clamp32(logic signed [127:0] v, ref logic flt);
		if (v > 128'sd2147483647) begin
			flt = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (v < -128'sd2147483648) begin
			flt = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Round a Q-scaled product sum to nearest, ties toward +infinity.
	function automatic logic signed [127:0] round_q(logic signed [127:0] v);
		return (v + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	// Rounded integer square root.
	function automatic logic [127:0] root_round(logic [127:0] s);
		logic [127:0] r, bitv;
		r = 0;
		bitv = 128'd1 << 126;
		while (bitv > s)
			bitv >>= 2;
		while (bitv != 0) begin
			if (s >= r + bitv) begin
				s -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		if (s > r)
			r++;
		return r;
	endfunction

	function automatic logic [127:0] abs128(logic signed [127:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic signed [31:0] vec_length(logic signed [127:0] d[3], ref logic flt);
		logic [127:0] s;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			if (abs128(d[i]) >= 128'h80000000) begin
				flt = 1'b1;
				return 32'sh7FFFFFFF;
			end
			s += abs128(d[i]) * abs128(d[i]);
		end
		return clamp32($signed(root_round(s)), flt);
	endfunction

	// Compute the expected result of one transaction.
	function automatic result_t predict_vector(request_t q);
		logic signed [127:0] a[3], b[3], t, d[3];
		logic signed [127:0] v[3];
		logic [127:0] m, s, len, quo;
		int k, j, n;
		logic flt;
		result_t r;
		r = '0;
		flt = 1'b0;
		a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z;
		b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z;
		t = q.scalar_t;
		for (int i = 0; i < 3; i++)
			d[i] = 0;
		case (q.command)
			CMD_ADD:   for (int i = 0; i < 3; i++) d[i] = clamp32(a[i] + b[i], flt);
			CMD_SUB:   for (int i = 0; i < 3; i++) d[i] = clamp32(a[i] - b[i], flt);
			CMD_MUL:   for (int i = 0; i < 3; i++) d[i] = clamp32(round_q(a[i] * b[i]), flt);
			CMD_LERP:  for (int i = 0; i < 3; i++)
				d[i] = clamp32(round_q((a[i] <<< FRAC) + (b[i] - a[i]) * t), flt);
			CMD_DOT:   r.r_scalar = clamp32(round_q(a[0]*b[0] + a[1]*b[1] + a[2]*b[2]), flt);
			CMD_CROSS: for (int i = 0; i < 3; i++) begin
				j = (i + 1) % 3;
				n = (i + 2) % 3;
				d[i] = clamp32(round_q(a[j]*b[n] - a[n]*b[j]), flt);
			end
			CMD_LENGTH: r.r_scalar = vec_length(a, flt);
			CMD_DIST: begin
				for (int i = 0; i < 3; i++)
					v[i] = a[i] - b[i];
				r.r_scalar = vec_length(v, flt);
			end
			CMD_SCALE: for (int i = 0; i < 3; i++) d[i] = clamp32(round_q(a[i] * t), flt);
			CMD_NORM: begin
				m = 0;
				for (int i = 0; i < 3; i++)
					if (abs128(a[i]) > m) m = abs128(a[i]);
				if (m == 0) begin
					flt = 1'b1;
				end else begin
					k = 0;
					while (m < 128'h40000000) begin
						m <<= 1;
						k++;
					end
					s = 0;
					for (int i = 0; i < 3; i++) begin
						v[i] = a[i] <<< k;
						s += abs128(v[i]) * abs128(v[i]);
					end
					len = root_round(s);
					for (int i = 0; i < 3; i++) begin
						quo = ((abs128(v[i]) << FRAC) + (len >> 1)) / len;
						d[i] = clamp32(v[i] < 0 ? -$signed(quo) : $signed(quo), flt);
					end
				end
			end
			default: ;
		endcase
		r.r_x = d[0][31:0];
		r.r_y = d[1][31:0];
		r.r_z = d[2][31:0];
		r.fault = flt;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, checked_count);
	endtask

	// Compare each strobed result with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", result.r_x, 32'h0);
			end else begin
				want = pending_results.pop_front();
				if (result.r_x !== want.r_x) report_mismatch("r_x", result.r_x, want.r_x);
				if (result.r_y !== want.r_y) report_mismatch("r_y", result.r_y, want.r_y);
				if (result.r_z !== want.r_z) report_mismatch("r_z", result.r_z, want.r_z);
				if (result.r_scalar !== want.r_scalar)
					report_mismatch("r_scalar", result.r_scalar, want.r_scalar);
				if (result.fault !== want.fault)
					report_mismatch("fault", {31'b0, result.fault}, {31'b0, want.fault});
			end
			checked_count++;
		end
	end

	// Send one transaction: idle randomly, raise start, hold until taken.
	task automatic send_vector(request_t q);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct)
				@(posedge clk);
		end
		start <= 1'b1;
		request <= q;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_vector(q));
		sent_count++;
	endtask

	// Random operand: mostly mid-range, sometimes full-scale or small.
	function automatic logic [31:0] rand_operand();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($signed(16'($urandom())));
			2: return {{8{1'b0}}, 24'($urandom())} ^ {32{$urandom_range(1)==1}};
			default: return 32'($signed(20'($urandom())));
		endcase
	endfunction

	function automatic request_t rand_request();
		request_t q;
		q.command = ($urandom_range(19) == 0) ? 4'($urandom()) : 4'($urandom_range(9));
		q.a_x = rand_operand(); q.a_y = rand_operand(); q.a_z = rand_operand();
		q.b_x = rand_operand(); q.b_y = rand_operand(); q.b_z = rand_operand();
		q.scalar_t = rand_operand();
		if ($urandom_range(29) == 0) begin
			q.a_x = 0; q.a_y = 0; q.a_z = 0;
		end
		return q;
	endfunction

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_corners();
		request_t q;
		logic [31:0] edges[4] = '{32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'h0};
		for (int c = 0; c <= 9; c++) begin
			q.command = 4'(c);
			q.a_x = edges[c % 4]; q.a_y = edges[(c + 1) % 4]; q.a_z = edges[(c + 2) % 4];
			q.b_x = edges[(c + 1) % 4]; q.b_y = edges[(c + 3) % 4]; q.b_z = edges[c % 4];
			q.scalar_t = edges[(c + 2) % 4];
			send_vector(q);
		end
		// zero-vector normalize, then a tiny one
		q = '0;
		q.command = CMD_NORM;
		send_vector(q);
		q.a_z = 32'hFFFFFFFF;
		send_vector(q);
		// huge distance, all-ones and all-zeros payloads, unknown codes
		q = '0;
		q.command = CMD_DIST; q.a_x = 32'h7FFFFFFF; q.b_x = 32'h80000000;
		send_vector(q);
		q = '1;
		send_vector(q);
		q = '0;
		q.command = 4'd10;
		send_vector(q);
		q.command = 4'd15; q.a_x = 32'h12345678;
		send_vector(q);
		// rounding ties on mul
		q = '0;
		q.command = CMD_MUL; q.a_x = 32'h00008000; q.b_x = 32'h00000001;
		q.a_y = 32'hFFFF8000; q.b_y = 32'h00000001;
		send_vector(q);
		wait_drained();
	endtask

	task automatic test_random_phase(int pct, int count);
		gap_pct = pct;
		for (int i = 0; i < count; i++)
			send_vector(rand_request());
	endtask

	task automatic test_drain_pause();
		// stop sending until every outstanding result is back
		wait_drained();
		repeat (3) @(posedge clk);
		test_random_phase(0, 20);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_random_phase(11, 650);
		test_random_phase(74, 650);
		test_drain_pause();
		test_random_phase(0, 630);
		wait_drained();
		repeat (200) @(posedge clk);
		$display("Sent %0d transactions over all ten commands and unknown codes;", sent_count);
		$display("checked %0d results under three idling profiles.", checked_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(8ns * 3000000);
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/v3a_pkg.sv
rtl/core/v3a_front.sv
rtl/core/v3a_pipe.sv
rtl/core/v3a_iter.sv
rtl/core/vector3_alu.sv
rtl/core/vector3_alu_checker.sv
tb/vector3_alu_tb.sv
